>>> src/mlfq_pkg.sv
`default_nettype none

package mlfq_pkg;

  localparam int LEVELS_DEF    = 4;
  localparam int MAX_PROCS_DEF = 16;

  localparam int ID_W       = 4;
  localparam int ID_SLOTS   = 16;
  localparam int TIME_W     = 16;
  localparam int SLICE_W    = 8;
  localparam int LVL_W      = 2;
  localparam int CODE_W     = 3;
  localparam int CNT_W      = 3;
  localparam int SLICE_REGS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]   LEVEL_COUNT_RST = 3'd4;
  localparam logic [SLICE_W-1:0] SLICE0_RST      = 8'd1;
  localparam logic [SLICE_W-1:0] SLICE1_RST      = 8'd2;
  localparam logic [SLICE_W-1:0] SLICE2_RST      = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE3_RST      = 8'd8;

  typedef enum logic [CODE_W-1:0] {
    EV_IDLE   = 3'd0,
    EV_ADDED  = 3'd1,
    EV_REJECT = 3'd2,
    EV_RUN    = 3'd3,
    EV_FINISH = 3'd4,
    EV_MOVED  = 3'd5
  } event_code_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_COUNT = 3'd0,
    CFG_SLICE0      = 3'd1,
    CFG_SLICE1      = 3'd2,
    CFG_SLICE2      = 3'd3,
    CFG_SLICE3      = 3'd4
  } cfg_reg_t;

  // per level queue control and status
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } fifo_ctl_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] head_id;
  } fifo_sts_t;

endpackage

`default_nettype wire

>>> src/mlfq_ifs.sv
`default_nettype none

interface mlfq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [mlfq_pkg::ID_W-1:0]   proc_id;
  logic [mlfq_pkg::TIME_W-1:0] need_time;

  modport source (output valid, operation, proc_id, need_time, input ready);
  modport sink   (input valid, operation, proc_id, need_time, output ready);
endinterface

interface mlfq_evt_if;
  logic                        valid;
  logic                        ready;
  logic [mlfq_pkg::CODE_W-1:0] event_code;
  logic [mlfq_pkg::ID_W-1:0]   event_proc;
  logic [mlfq_pkg::LVL_W-1:0]  event_level;
  logic [mlfq_pkg::TIME_W-1:0] used_time;
  logic [mlfq_pkg::TIME_W-1:0] remaining_time;

  modport source (output valid, event_code, event_proc, event_level, used_time,
                  remaining_time, input ready);
  modport sink   (input valid, event_code, event_proc, event_level, used_time,
                  remaining_time, output ready);
endinterface

interface mlfq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mlfq_pkg::CFG_IDX_W-1:0]  index;
  logic [mlfq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/mlfq_level_fifo.sv
`default_nettype none

module mlfq_level_fifo #(
  parameter int DEPTH = mlfq_pkg::MAX_PROCS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mlfq_pkg::fifo_ctl_t ctl,
  output mlfq_pkg::fifo_sts_t sts
);
  import mlfq_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [ID_W-1:0]   entries [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;

  assign head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_next = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);

  assign sts.empty   = (fill == '0);
  assign sts.full    = (fill == FILL_W'(DEPTH));
  assign sts.head_id = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctl.pop) begin
        head <= head_next;
      end
      if (ctl.push) begin
        tail <= tail_next;
      end
      case ({ctl.push, ctl.pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[tail] <= ctl.push_id;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !sts.empty)
    else $error("pop from empty level queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && !ctl.pop) |-> !sts.full)
    else $error("push into full level queue");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("level queue fill out of range");

endmodule

`default_nettype wire

>>> src/multilevel_feedback_scheduler_top.sv
`default_nettype none

// multilevel feedback queue scheduler
// cmd: one item per transfer; operation add enqueues proc_id with need_time at
//   the tail of level 0, operation tick dispatches the head of the lowest numbered
//   non-empty level if nothing runs and lets the running process use one tick
// evt: exactly one event per cmd transfer, in order (idle, added, rejected,
//   ran, finished, moved) with the process, its level and its times
// cfg: register writes (level count, four slices), always ready; write only
//   while no command is in flight
// path: a cmd transfer is registered in the command register, then evaluated
//   combinationally into the event register, which drives evt.valid
// throughput: one item per cycle while evt takes each event; the whole scheduling
//   decision (priority pick over the level queues, per process store read, update)
//   sits between the command register and the event register
// when evt stalls the event register holds, the command register fills and
//   cmd.ready drops until the event is taken
// reset clears busy flags, queues, the running process and the config
//   registers to four levels with slices 1, 2, 4, 8; no clearing pass
module multilevel_feedback_scheduler_top #(
  parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int MAX_PROCS = mlfq_pkg::MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mlfq_cmd_if.sink   cmd,
  mlfq_evt_if.source evt,
  mlfq_cfg_if.sink   cfg
);
  import mlfq_pkg::*;

  localparam int LVL_CAP = (LEVELS < SLICE_REGS) ? LEVELS : SLICE_REGS;
  localparam int SEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // configuration registers
  logic [CNT_W-1:0]   level_count;
  logic [SLICE_W-1:0] slice [SLICE_REGS];

  // command register
  logic              in_valid;
  op_t               in_op;
  logic [ID_W-1:0]   in_id;
  logic [TIME_W-1:0] in_need;

  // event register
  logic              out_valid;
  event_code_t       out_code;
  logic [ID_W-1:0]   out_proc;
  logic [LVL_W-1:0]  out_level;
  logic [TIME_W-1:0] out_used;
  logic [TIME_W-1:0] out_rem;

  // scheduler state
  logic [ID_SLOTS-1:0] busy;
  logic                running_valid;
  logic [ID_W-1:0]     running_proc;
  logic [SLICE_W-1:0]  slice_count;

  // per process stores, undefined until an add writes them
  logic [TIME_W-1:0] rem_store   [ID_SLOTS];
  logic [TIME_W-1:0] used_store  [ID_SLOTS];
  logic [LVL_W-1:0]  level_store [ID_SLOTS];

  // level queues
  fifo_ctl_t fifo_ctl [LEVELS];
  fifo_sts_t fifo_sts [LEVELS];

  // combinational decision
  logic               advance;
  logic               is_add;
  logic               is_tick;
  logic               add_ok;
  logic               add_fire;
  logic               found;
  logic [SEL_W-1:0]   sel;
  logic [ID_W-1:0]    p;
  logic [LVL_W-1:0]   cur_level;
  logic [TIME_W-1:0]  cur_rem;
  logic [TIME_W-1:0]  cur_used;
  logic [TIME_W-1:0]  used_inc;
  logic [TIME_W-1:0]  rem_dec;
  logic [SLICE_W-1:0] slice_base;
  logic [SLICE_W-1:0] slice_inc;
  logic [SLICE_W-1:0] slice_eff;
  logic [CNT_W-1:0]   n_use;
  logic [CNT_W-1:0]   lvl_plus;
  logic [LVL_W-1:0]   next_lvl;
  logic               tick_fire;
  logic               pop_fire;
  logic               finish;
  logic               expire;
  logic               push_fire;
  logic [LEVELS-1:0]  pop_vec;

  event_code_t       code_next;
  logic [ID_W-1:0]   proc_next;
  logic [LVL_W-1:0]  level_next;
  logic [TIME_W-1:0] used_next;
  logic [TIME_W-1:0] rem_next;

  // handshakes: the command register empties whenever the event register can take
  assign advance   = in_valid && (!out_valid || evt.ready);
  assign cmd.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign evt.valid          = out_valid;
  assign evt.event_code     = out_code;
  assign evt.event_proc     = out_proc;
  assign evt.event_level    = out_level;
  assign evt.used_time      = out_used;
  assign evt.remaining_time = out_rem;

  assign is_add  = advance && (in_op == OP_ADD);
  assign is_tick = advance && (in_op == OP_TICK);

  // add path: id free, in range, level 0 has room
  assign add_ok   = !busy[in_id] && (int'(in_id) < MAX_PROCS) && !fifo_sts[0].full;
  assign add_fire = is_add && add_ok;

  // levels in use: zero acts as one, capped at the number of queues and slice registers
  always_comb begin
    if (level_count == '0) begin
      n_use = CNT_W'(1);
    end else if (level_count > CNT_W'(LVL_CAP)) begin
      n_use = CNT_W'(LVL_CAP);
    end else begin
      n_use = level_count;
    end
  end

  // priority pick, lowest level number wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (!fifo_sts[l].empty) begin
        found = 1'b1;
        sel   = SEL_W'(l);
      end
    end
  end

  // running process, or the one being dispatched now
  assign p         = running_valid ? running_proc : fifo_sts[sel].head_id;
  assign cur_level = running_valid ? level_store[p] : LVL_W'(sel);
  assign cur_rem   = rem_store[p];
  assign cur_used  = used_store[p];

  // one tick of work, both times saturate
  assign used_inc   = (cur_used != '1) ? cur_used + TIME_W'(1) : cur_used;
  assign rem_dec    = (cur_rem != '0) ? cur_rem - TIME_W'(1) : '0;
  assign slice_base = running_valid ? slice_count : '0;
  assign slice_inc  = (slice_base != '1) ? slice_base + SLICE_W'(1) : slice_base;
  assign slice_eff  = (slice[cur_level] == '0) ? SLICE_W'(1) : slice[cur_level];

  assign finish = (rem_dec == '0);
  assign expire = !finish && (slice_inc >= slice_eff);

  // demotion target, the last level in use keeps round robin
  assign lvl_plus = CNT_W'(cur_level) + CNT_W'(1);
  assign next_lvl = (lvl_plus < n_use) ? LVL_W'(lvl_plus) : LVL_W'(n_use - CNT_W'(1));

  assign tick_fire = is_tick && (running_valid || found);
  assign pop_fire  = is_tick && !running_valid && found;

  // push on expiry; room is guaranteed if the same queue pops this cycle
  always_comb begin
    push_fire = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (int'(next_lvl) == l) begin
        push_fire = tick_fire && expire &&
                    (!fifo_sts[l].full || (pop_fire && (int'(sel) == l)));
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      fifo_ctl[l] = '0;
      if (add_fire && (l == 0)) begin
        fifo_ctl[l].push    = 1'b1;
        fifo_ctl[l].push_id = in_id;
      end
      if (push_fire && (int'(next_lvl) == l)) begin
        fifo_ctl[l].push    = 1'b1;
        fifo_ctl[l].push_id = p;
      end
      if (pop_fire && (int'(sel) == l)) begin
        fifo_ctl[l].pop = 1'b1;
      end
      pop_vec[l] = fifo_ctl[l].pop;
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    mlfq_level_fifo #(
      .DEPTH(MAX_PROCS)
    ) u_fifo (
      .clk(clk),
      .rst(rst),
      .ctl(fifo_ctl[g]),
      .sts(fifo_sts[g])
    );
  end

  // event contents
  always_comb begin
    code_next  = EV_IDLE;
    proc_next  = '0;
    level_next = '0;
    used_next  = '0;
    rem_next   = '0;
    if (in_op == OP_ADD) begin
      proc_next = in_id;
      if (add_ok) begin
        code_next = EV_ADDED;
        rem_next  = in_need;
      end else begin
        code_next = EV_REJECT;
      end
    end else if (running_valid || found) begin
      proc_next = p;
      used_next = used_inc;
      if (finish) begin
        code_next  = EV_FINISH;
        level_next = cur_level;
      end else if (expire) begin
        code_next  = EV_MOVED;
        level_next = next_lvl;
        rem_next   = rem_dec;
      end else begin
        code_next  = EV_RUN;
        level_next = cur_level;
        rem_next   = rem_dec;
      end
    end
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      busy          <= '0;
      running_valid <= 1'b0;
      running_proc  <= '0;
      slice_count   <= '0;
      level_count   <= LEVEL_COUNT_RST;
      slice[0]      <= SLICE0_RST;
      slice[1]      <= SLICE1_RST;
      slice[2]      <= SLICE2_RST;
      slice[3]      <= SLICE3_RST;
    end else begin
      if (cmd.valid && cmd.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end

      if (add_fire) begin
        busy[in_id] <= 1'b1;
      end

      if (tick_fire) begin
        if (finish) begin
          busy[p]       <= 1'b0;
          running_valid <= 1'b0;
          slice_count   <= '0;
        end else if (expire) begin
          running_valid <= 1'b0;
          slice_count   <= '0;
        end else begin
          running_valid <= 1'b1;
          running_proc  <= p;
          slice_count   <= slice_inc;
        end
      end

      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          CFG_LEVEL_COUNT: level_count <= cfg.data[CNT_W-1:0];
          CFG_SLICE0:      slice[0]    <= cfg.data[SLICE_W-1:0];
          CFG_SLICE1:      slice[1]    <= cfg.data[SLICE_W-1:0];
          CFG_SLICE2:      slice[2]    <= cfg.data[SLICE_W-1:0];
          CFG_SLICE3:      slice[3]    <= cfg.data[SLICE_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  // payload registers and per process stores
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_op   <= op_t'(cmd.operation);
      in_id   <= cmd.proc_id;
      in_need <= cmd.need_time;
    end

    if (advance) begin
      out_code  <= code_next;
      out_proc  <= proc_next;
      out_level <= level_next;
      out_used  <= used_next;
      out_rem   <= rem_next;
    end

    if (add_fire) begin
      rem_store[in_id]   <= in_need;
      used_store[in_id]  <= '0;
      level_store[in_id] <= '0;
    end

    if (tick_fire) begin
      rem_store[p]   <= rem_dec;
      used_store[p]  <= used_inc;
      level_store[p] <= expire ? next_lvl : cur_level;
    end
  end

  a_running_busy: assert property (@(posedge clk) disable iff (rst)
    running_valid |-> busy[running_proc])
    else $error("running process not marked busy");

  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pop_vec))
    else $error("more than one level dispatched");

  a_finished_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_code == EV_FINISH)) |-> !busy[out_proc])
    else $error("finished process still busy");

endmodule

`default_nettype wire

>>> tb/tb_multilevel_feedback_scheduler_top.sv
`default_nettype none

module tb_multilevel_feedback_scheduler_top;
  import mlfq_pkg::*;

  localparam int NUM_LEVELS    = LEVELS_DEF;
  localparam int NUM_PROCS     = MAX_PROCS_DEF;
  localparam int ITEMS_PER_SET = 210;
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on any channel
  localparam int HOLD_AT       = 400;   // event count that starts the long output stall
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 4;     // pipeline latency plus margin

  // one command as the scheduler sees it
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] need;
  } sched_cmd_t;

  // one scheduler event
  typedef struct packed {
    event_code_t       code;
    logic [ID_W-1:0]   proc;
    logic [LVL_W-1:0]  lvl;
    logic [TIME_W-1:0] used;
    logic [TIME_W-1:0] rem;
  } sched_evt_t;

  logic clk = 1'b0;
  logic rst;

  mlfq_cmd_if cmd_bus ();
  mlfq_evt_if evt_bus ();
  mlfq_cfg_if cfg_bus ();

  multilevel_feedback_scheduler_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .evt (evt_bus),
    .cfg (cfg_bus)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // scheduler shadow: register copies and per process bookkeeping
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   sh_level_count;
  logic [SLICE_W-1:0] sh_slice [SLICE_REGS];

  logic [TIME_W-1:0]  rem_tbl  [ID_SLOTS];
  logic [TIME_W-1:0]  used_tbl [ID_SLOTS];
  logic [LVL_W-1:0]   lvl_tbl  [ID_SLOTS];
  logic [ID_SLOTS-1:0] busy_ids;

  // one ring buffer of ready process ids per level
  logic [ID_W-1:0]    ready_ring [NUM_LEVELS][NUM_PROCS];
  int unsigned        ring_head  [NUM_LEVELS];
  int unsigned        ring_tail  [NUM_LEVELS];
  int unsigned        ring_fill  [NUM_LEVELS];

  logic [ID_W-1:0]    run_id;
  bit                 run_active;
  logic [SLICE_W-1:0] run_ticks;

  // stimulus and expectation stores
  sched_cmd_t  pending_cmds[$];
  sched_evt_t  expected_events[$];
  int unsigned cmds_queued;
  int unsigned cmds_accepted;
  int unsigned events_seen;
  int unsigned errors;
  int unsigned settings_used;
  int unsigned code_tally [6];

  // idle ranges per side, changed between register settings
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;

  function automatic sched_evt_t make_event(event_code_t code, logic [ID_W-1:0] p,
                                            logic [LVL_W-1:0] l, logic [TIME_W-1:0] u,
                                            logic [TIME_W-1:0] r);
    sched_evt_t e;
    e.code = code;
    e.proc = p;
    e.lvl  = l;
    e.used = u;
    e.rem  = r;
    return e;
  endfunction

  // append to a level's ready ring; false when the level is full or out of range
  function automatic bit ring_push(int unsigned lv, logic [ID_W-1:0] id);
    if (lv >= NUM_LEVELS || ring_fill[lv] >= NUM_PROCS) return 1'b0;
    ready_ring[lv][ring_tail[lv]] = id;
    ring_tail[lv] = (ring_tail[lv] + 1 >= NUM_PROCS) ? 0 : ring_tail[lv] + 1;
    ring_fill[lv]++;
    return 1'b1;
  endfunction

  // one scheduling decision: update the shadow and return the event it gives
  function automatic sched_evt_t schedule_step(sched_cmd_t c);
    int unsigned n, lv, nxt, sl;
    logic [ID_W-1:0]   p;
    logic [TIME_W-1:0] rem, used;
    bit found;

    if (c.op == OP_ADD) begin
      // busy id or full top level: rejected, nothing changes
      if (busy_ids[c.id] || !ring_push(0, c.id))
        return make_event(EV_REJECT, c.id, '0, '0, '0);
      rem_tbl[c.id]  = c.need;
      used_tbl[c.id] = '0;
      lvl_tbl[c.id]  = '0;
      busy_ids[c.id] = 1'b1;
      return make_event(EV_ADDED, c.id, '0, '0, c.need);
    end

    // dispatch from the highest priority non-empty level, every level scanned
    if (!run_active) begin
      found = 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (!found && ring_fill[l] != 0) begin
          run_id = ready_ring[l][ring_head[l]];
          ring_head[l] = (ring_head[l] + 1 >= NUM_PROCS) ? 0 : ring_head[l] + 1;
          ring_fill[l]--;
          lvl_tbl[run_id] = LVL_W'(l);
          found = 1'b1;
        end
      end
      if (!found) return make_event(EV_IDLE, '0, '0, '0, '0);
      run_active = 1'b1;
      run_ticks  = '0;
    end

    p    = run_id;
    lv   = lvl_tbl[p];
    rem  = rem_tbl[p];
    used = used_tbl[p];
    // level count 0 acts as 1, above the level range acts as the top
    n = sh_level_count;
    if (n < 1) n = 1;
    if (n > NUM_LEVELS) n = NUM_LEVELS;
    if (n > 4) n = 4;

    if (used != '1) used++;
    if (rem != '0) rem--;
    used_tbl[p] = used;
    rem_tbl[p]  = rem;
    if (run_ticks != '1) run_ticks++;

    if (rem == '0) begin
      busy_ids[p] = 1'b0;
      run_active  = 1'b0;
      run_ticks   = '0;
      return make_event(EV_FINISH, p, LVL_W'(lv), used, '0);
    end

    // zero slice acts as one tick
    sl = sh_slice[lv < 4 ? lv : 3];
    if (sl == 0) sl = 1;
    if (run_ticks >= sl) begin
      nxt = (lv + 1 < n) ? lv + 1 : n - 1;
      lvl_tbl[p] = LVL_W'(nxt);
      void'(ring_push(nxt, p));
      run_active = 1'b0;
      run_ticks  = '0;
      return make_event(EV_MOVED, p, LVL_W'(nxt), used, rem);
    end
    return make_event(EV_RUN, p, LVL_W'(lv), used, rem);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: one item at a time from pending_cmds, random gap after each
  // ---------------------------------------------------------------------------
  sched_cmd_t  drv_cmd;
  int unsigned tx_wait;

  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      tx_wait       <= 0;
    end else begin
      // prediction happens at the transfer, in acceptance order
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_events.push_back(schedule_step(drv_cmd));
        cmds_accepted++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (tx_wait != 0) begin
          cmd_bus.valid <= 1'b0;
          tx_wait       <= tx_wait - 1;
        end else if (pending_cmds.size() != 0) begin
          drv_cmd             <= pending_cmds[0];
          cmd_bus.valid       <= 1'b1;
          cmd_bus.operation   <= pending_cmds[0].op;
          cmd_bus.proc_id     <= pending_cmds[0].id;
          cmd_bus.need_time   <= pending_cmds[0].need;
          tx_wait             <= $urandom_range(0, tx_gap_max);
          void'(pending_cmds.pop_front());
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event monitor: compares each transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  int unsigned rx_wait;
  int unsigned hold_left;

  task automatic report_field(string name, longint unsigned want, longint unsigned seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    sched_evt_t  want, seen;
    int unsigned w;
    if (rst) begin
      evt_bus.ready <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      w = rx_wait;
      if (evt_bus.valid && evt_bus.ready) begin
        seen.code = event_code_t'(evt_bus.event_code);
        seen.proc = evt_bus.event_proc;
        seen.lvl  = evt_bus.event_level;
        seen.used = evt_bus.used_time;
        seen.rem  = evt_bus.remaining_time;
        if (expected_events.size() == 0) begin
          $display("%0t: event with none expected: code %0d proc %0d", $time,
                   seen.code, seen.proc);
          errors++;
        end else begin
          want = expected_events.pop_front();
          report_field("event_code", want.code, seen.code);
          report_field("event_proc", want.proc, seen.proc);
          report_field("event_level", want.lvl, seen.lvl);
          report_field("used_time", want.used, seen.used);
          report_field("remaining_time", want.rem, seen.rem);
        end
        if (seen.code <= EV_MOVED) code_tally[seen.code]++;
        events_seen++;
        w = $urandom_range(0, rx_gap_max);
        // one long stall so the command side backs up
        if (events_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        evt_bus.ready <= 1'b0;
      end else if (w != 0) begin
        w--;
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= 1'b1;
      end
      rx_wait = w;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer ends the run
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_bus.valid && cmd_bus.ready) || (evt_bus.valid && evt_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("multilevel_feedback_scheduler_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequencing
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(op_t op, logic [ID_W-1:0] id, logic [TIME_W-1:0] need);
    sched_cmd_t c;
    c.op   = op;
    c.id   = id;
    c.need = need;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // every command transferred and every event returned
  task automatic wait_drained();
    do @(posedge clk);
    while (cmds_accepted != cmds_queued || expected_events.size() != 0);
  endtask

  // one register write; the caller lowers valid after the last one
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk);
    while (!cfg_bus.ready);
    if (idx == CFG_LEVEL_COUNT) sh_level_count = val[CNT_W-1:0];
    else sh_slice[idx - CFG_SLICE0] = val;
  endtask

  task automatic apply_setting(logic [CNT_W-1:0] lc, logic [SLICE_W-1:0] s0,
                               logic [SLICE_W-1:0] s1, logic [SLICE_W-1:0] s2,
                               logic [SLICE_W-1:0] s3);
    cfg_write(CFG_LEVEL_COUNT, CFG_DATA_W'(lc));
    cfg_write(CFG_SLICE0, s0);
    cfg_write(CFG_SLICE1, s1);
    cfg_write(CFG_SLICE2, s2);
    cfg_write(CFG_SLICE3, s3);
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SLICE_W-1:0] pick_slice();
    // mostly short slices so moves are frequent, now and then any value
    if ($urandom_range(0, 7) == 0) return SLICE_W'($urandom_range(0, 255));
    return SLICE_W'($urandom_range(0, 10));
  endfunction

  // random mix: mostly ticks, adds with random ids and short needs
  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 30)
        queue_cmd(OP_ADD, ID_W'($urandom_range(0, ID_SLOTS - 1)),
                  ($urandom_range(0, 19) == 0) ? TIME_W'($urandom_range(0, 2))
                                               : TIME_W'($urandom_range(1, 24)));
      else
        queue_cmd(OP_TICK, ID_W'($urandom), TIME_W'($urandom));
    end
  endtask

  initial begin
    // every block input known from time zero
    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.operation   = OP_TICK;
    cmd_bus.proc_id     = '0;
    cmd_bus.need_time   = '0;
    evt_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_LEVEL_COUNT;
    cfg_bus.data        = '0;

    // shadow starts from the reset state of the block
    sh_level_count = LEVEL_COUNT_RST;
    sh_slice[0]    = SLICE0_RST;
    sh_slice[1]    = SLICE1_RST;
    sh_slice[2]    = SLICE2_RST;
    sh_slice[3]    = SLICE3_RST;
    busy_ids       = '0;
    run_id         = '0;
    run_active     = 1'b0;
    run_ticks      = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ring_head[l] = 0;
      ring_tail[l] = 0;
      ring_fill[l] = 0;
    end
    for (int k = 0; k < 6; k++) code_tally[k] = 0;
    cmds_queued   = 0;
    cmds_accepted = 0;
    events_seen   = 0;
    errors        = 0;
    settings_used = 1;
    tx_gap_max    = 0;
    rx_gap_max    = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening under reset settings (slices 1, 2, 4, 8)
    queue_cmd(OP_TICK, '1, '1);            // idle tick, nothing queued
    queue_cmd(OP_ADD, 4'd0, 16'd1);        // smallest id, one tick of work
    queue_cmd(OP_ADD, 4'd15, 16'hFFFF);    // largest id, largest need
    queue_cmd(OP_ADD, 4'd0, 16'd5);        // id still queued: rejected
    queue_cmd(OP_ADD, 4'd7, 16'd0);        // zero need finishes on first tick
    queue_cmd(OP_TICK, '0, '0);            // id 0 finishes at level 0
    queue_cmd(OP_TICK, '0, '0);            // id 15 runs one slice, moves down
    queue_cmd(OP_ADD, 4'd0, 16'd3);        // finished id can come back
    queue_cmd(OP_TICK, '0, '0);            // id 7 finishes with zero remaining
    queue_cmd(OP_TICK, '0, '0);            // id 0 again
    queue_cmd(OP_ADD, 4'd3, 16'd2);        // arrival while id 0 is not running
    queue_cmd(OP_TICK, '0, '0);
    queue_cmd(OP_TICK, '0, '0);
    queue_cmd(OP_ADD, 4'd15, 16'd4);       // running/queued id rejected
    for (int i = 0; i < 10; i++) queue_cmd(OP_TICK, '0, '0);  // down to the last level
    queue_random(ITEMS_PER_SET);
    wait_drained();

    // register settings, extremes first, then random ones
    for (int s = 1; s <= 8; s++) begin
      tx_gap_max = (s % 3 == 0) ? 0 : 14;
      rx_gap_max = (s % 2 == 0) ? 0 : 14;
      case (s)
        1:       apply_setting(3'd1, 8'd255, 8'd255, 8'd255, 8'd255);
        2:       apply_setting(3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        3:       apply_setting(3'd7, 8'd1, 8'd2, 8'd3, 8'd4);
        4:       apply_setting(3'd2, 8'd3, 8'd7, 8'd1, 8'd1);
        default: apply_setting(CNT_W'($urandom_range(0, 7)), pick_slice(), pick_slice(),
                               pick_slice(), pick_slice());
      endcase
      queue_random(ITEMS_PER_SET);
      wait_drained();
    end

    // last events have been checked; give the block a few cycles to misbehave
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands under %0d register settings, one long output stall",
             cmds_accepted, settings_used);
    $display("events: idle %0d added %0d rejected %0d ran %0d finished %0d moved %0d",
             code_tally[EV_IDLE], code_tally[EV_ADDED], code_tally[EV_REJECT],
             code_tally[EV_RUN], code_tally[EV_FINISH], code_tally[EV_MOVED]);
    if (errors == 0) begin
      $display("multilevel_feedback_scheduler_top: match");
    end else begin
      $display("multilevel_feedback_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
